FILE: hdl/leb_pkg.sv
// shared types and constants for the led brightness effect generator
package leb_pkg;

   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_OFF       = 3'd1,
      ACT_ON        = 3'd2,
      ACT_BREATH    = 3'd3,
      ACT_FADE_DOWN = 3'd4,
      ACT_FADE_UP   = 3'd5,
      ACT_BLINK     = 3'd6,
      ACT_DIM       = 3'd7
   } action_type;

   localparam logic [7:0]  LEVEL_MAX       = 8'd255;
   localparam logic [7:0]  LEVEL_RESET     = 8'd125;
   localparam logic [7:0]  FADE_STEP_RESET = 8'd5;
   localparam logic [32:0] DELAY_RESET     = 33'd30;
   localparam logic [32:0] DELAY_ONOFF     = 33'd10;
   localparam logic [32:0] DELAY_DIM       = 33'd1000;

   typedef struct packed {
      action_type  action;
      logic [15:0] step_delay;
      logic [7:0]  dim_level;
   } req_word_type;

   typedef struct packed {
      action_type mode;
      logic [7:0] level;
      logic       going_down;
   } led_state_type;

   // clamp a delay value to the largest value of a bits-wide counter
   function automatic logic [31:0] fit_delay(logic [32:0] v, int bits);
      logic [32:0] lim;
      lim = (33'd1 << bits) - 33'd1;
      if (v > lim) begin
         return lim[31:0];
      end
      return v[31:0];
   endfunction

endpackage

FILE: hdl/leb_channels.sv
// valid/ready channel interfaces for request and response words
interface leb_req_if;
   logic                 valid;
   logic                 ready;
   leb_pkg::action_type  action;
   logic [15:0]          step_delay;
   logic [7:0]           dim_level;

   modport source (output valid, action, step_delay, dim_level, input ready);
   modport sink   (input valid, action, step_delay, dim_level, output ready);
endinterface

interface leb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] brightness;

   modport source (output valid, brightness, input ready);
   modport sink   (input valid, brightness, output ready);
endinterface

FILE: hdl/leb_update.sv
// next-state logic for one word: tick stepping and mode commands
module leb_update #(
   parameter int DELAY_BITS = 16
) (
   input  leb_pkg::req_word_type  word,
   input  logic [7:0]             fade_step,
   input  leb_pkg::led_state_type state_cur,
   input  logic [DELAY_BITS-1:0]  delay_cur,
   input  logic [DELAY_BITS-1:0]  elapsed_cur,
   output leb_pkg::led_state_type state_nxt,
   output logic [DELAY_BITS-1:0]  delay_nxt,
   output logic [DELAY_BITS-1:0]  elapsed_nxt
);
   import leb_pkg::*;

   localparam logic [DELAY_BITS-1:0] DelayMax = {DELAY_BITS{1'b1}};

   logic [DELAY_BITS-1:0] sd_fit;
   logic [DELAY_BITS-1:0] onoff_fit;
   logic [DELAY_BITS-1:0] dim_fit;
   logic [DELAY_BITS-1:0] elapsed_inc;
   logic [8:0]            up_sum;
   logic [7:0]            lvl_down;
   logic [7:0]            lvl_up;
   logic [7:0]            lvl_breath;

   assign sd_fit    = DELAY_BITS'(fit_delay({17'd0, word.step_delay}, DELAY_BITS));
   assign onoff_fit = DELAY_BITS'(fit_delay(DELAY_ONOFF, DELAY_BITS));
   assign dim_fit   = DELAY_BITS'(fit_delay(DELAY_DIM, DELAY_BITS));

   assign elapsed_inc = (elapsed_cur != DelayMax) ? elapsed_cur + 1'b1 : elapsed_cur;

   assign lvl_down   = (state_cur.level > fade_step) ? state_cur.level - fade_step : 8'd0;
   assign up_sum     = {1'b0, state_cur.level} + {1'b0, fade_step};
   assign lvl_up     = up_sum[8] ? LEVEL_MAX : up_sum[7:0];
   assign lvl_breath = state_cur.going_down ? lvl_down : lvl_up;

   always_comb begin
      state_nxt   = state_cur;
      delay_nxt   = delay_cur;
      elapsed_nxt = elapsed_cur;
      case (word.action)
         ACT_TICK: begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > delay_cur) begin
               elapsed_nxt = '0;
               case (state_cur.mode)
                  ACT_OFF: state_nxt.level = 8'd0;
                  ACT_ON:  state_nxt.level = LEVEL_MAX;
                  ACT_BREATH: begin
                     state_nxt.level = lvl_breath;
                     if (lvl_breath == 8'd0) begin
                        state_nxt.going_down = 1'b0;
                     end else if (lvl_breath == LEVEL_MAX) begin
                        state_nxt.going_down = 1'b1;
                     end
                  end
                  ACT_FADE_DOWN: state_nxt.level = (lvl_down == 8'd0) ? LEVEL_MAX : lvl_down;
                  ACT_FADE_UP:   state_nxt.level = (lvl_up == LEVEL_MAX) ? 8'd0 : lvl_up;
                  ACT_BLINK:
                     state_nxt.level = (state_cur.level == LEVEL_MAX) ? 8'd0 : LEVEL_MAX;
                  default: ;
               endcase
            end
         end
         ACT_OFF, ACT_ON: begin
            state_nxt.mode = word.action;
            delay_nxt      = onoff_fit;
         end
         ACT_BREATH: begin
            if (state_cur.level == 8'd0) begin
               state_nxt.going_down = 1'b0;
            end else if (state_cur.level == LEVEL_MAX) begin
               state_nxt.going_down = 1'b1;
            end
            state_nxt.mode = word.action;
            delay_nxt      = sd_fit;
         end
         ACT_FADE_DOWN: begin
            if (state_cur.level == 8'd0) begin
               state_nxt.level = LEVEL_MAX;
            end
            state_nxt.going_down = 1'b1;
            state_nxt.mode       = word.action;
            delay_nxt            = sd_fit;
         end
         ACT_FADE_UP: begin
            if (state_cur.level == LEVEL_MAX) begin
               state_nxt.level = 8'd0;
            end
            state_nxt.going_down = 1'b0;
            state_nxt.mode       = word.action;
            delay_nxt            = sd_fit;
         end
         ACT_BLINK: begin
            state_nxt.mode = word.action;
            delay_nxt      = sd_fit;
         end
         default: begin
            state_nxt.mode  = ACT_DIM;
            state_nxt.level = word.dim_level;
            delay_nxt       = dim_fit;
         end
      endcase
   end

endmodule

FILE: hdl/led_brightness_effect_generator.sv
// top level: input register, effect state update and response register
//
//   channel   | direction | contents
//   req_ch    | in        | action, step_delay, dim_level
//   rsp_ch    | out       | brightness, one word per request
//   csr_*     | in        | fade_step write, no read-back
//
// one request per cycle sustained while rsp_ch.ready is high; rsp valid rises as a word
// moves from the input register to the response register, and the effect state (mode,
// level, direction, delay, elapsed) updates in that same move.
// reset is synchronous; after it req_ch.ready is high and fade_step is 5.
// a stalled response holds its word; the input register still fills, then ready drops.
module led_brightness_effect_generator #(
   parameter int DELAY_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   leb_req_if.sink    req_ch,
   leb_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   import leb_pkg::*;

   req_word_type          word_ff,       word_in;
   logic                  word_valid_ff, word_valid_in;
   led_state_type         state_ff,      state_in;
   logic [DELAY_BITS-1:0] delay_ff,      delay_in;
   logic [DELAY_BITS-1:0] elapsed_ff,    elapsed_in;
   logic [7:0]            fade_step_ff,  fade_step_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [7:0]            bright_ff,     bright_in;

   led_state_type         state_upd;
   logic [DELAY_BITS-1:0] delay_upd;
   logic [DELAY_BITS-1:0] elapsed_upd;
   logic                  advance;
   logic                  take_req;

   leb_update #(.DELAY_BITS(DELAY_BITS)) u_update (
      .word        (word_ff),
      .fade_step   (fade_step_ff),
      .state_cur   (state_ff),
      .delay_cur   (delay_ff),
      .elapsed_cur (elapsed_ff),
      .state_nxt   (state_upd),
      .delay_nxt   (delay_upd),
      .elapsed_nxt (elapsed_upd)
   );

   // input word moves on when the response slot is empty or being drained
   assign advance       = word_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !word_valid_ff || advance;
   assign take_req      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.brightness = bright_ff;

   always_comb begin
      word_in       = take_req ? req_word_type'{action: req_ch.action,
                                                step_delay: req_ch.step_delay,
                                                dim_level: req_ch.dim_level} : word_ff;
      word_valid_in = take_req || (word_valid_ff && !advance);
      state_in      = advance ? state_upd : state_ff;
      delay_in      = advance ? delay_upd : delay_ff;
      elapsed_in    = advance ? elapsed_upd : elapsed_ff;
      bright_in     = advance ? state_upd.level : bright_ff;
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ch.ready);
      fade_step_in  = csr_we ? csr_wdata : fade_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{mode: ACT_OFF, level: LEVEL_RESET, going_down: 1'b0};
         delay_ff      <= DELAY_BITS'(fit_delay(DELAY_RESET, DELAY_BITS));
         elapsed_ff    <= '0;
         fade_step_ff  <= FADE_STEP_RESET;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
         delay_ff      <= delay_in;
         elapsed_ff    <= elapsed_in;
         fade_step_ff  <= fade_step_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      bright_ff <= bright_in;
   end

endmodule

FILE: hdl/leb_checker.sv
// port-level checks for the led brightness effect generator, bound to the top level
module leb_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_action,
   input logic [7:0] req_dim_level,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_brightness
);
   import leb_pkg::*;

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_brightness))
      else $error("stalled response word changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the response slot empty the block must take a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while response slot empty");

   // a dim command reports its level, through the input and response registers, when the output drains
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_DIM) ##1 rsp_ready
      |=> rsp_valid && rsp_brightness == $past(req_dim_level, 2))
      else $error("dim command did not report its level");

endmodule

bind led_brightness_effect_generator leb_port_checks u_leb_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_action     (req_ch.action),
   .req_dim_level  (req_ch.dim_level),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_brightness (rsp_ch.brightness)
);
